### rtl/core/fblc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblc_pkg - shared types for the free block list coalescer
// Entry layout, write-port bundle, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package fblc_pkg;

    localparam int FREE_DEPTH = 64;
    localparam int IDX_W      = $clog2(FREE_DEPTH);
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int WORD_W     = 32;

    typedef enum logic [1:0] {
        OP_RELEASE = 2'd0,
        OP_APPEND  = 2'd1,
        OP_SET_END = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_DEC1,
        ST_DEC2,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] off;
        logic [WORD_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

endpackage

### rtl/core/fblc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblc_ram - generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fblc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fblc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fblc_ctrl - free list sequencer
// Scans the sorted list in RAM, decides on merges and shifts entries.
// ----------------------------------------------------------------------------
module fblc_ctrl (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [1:0]                              operation,
    input  logic [fblc_pkg::WORD_W-1:0]             block_offset,
    input  logic [fblc_pkg::WORD_W-1:0]             block_size,
    output logic                                    busy,
    output logic                                    done,
    output logic                                    status,
    output logic [6:0]                              entry_count,
    output logic [fblc_pkg::WORD_W-1:0]             data_end_now,
    output fblc_pkg::ram_wr_t                       wr,
    output logic [fblc_pkg::IDX_W-1:0]              rd_addr,
    input  fblc_pkg::entry_t                        rd_data
);

    localparam logic [fblc_pkg::CNT_W-1:0] FULL_CNT = fblc_pkg::CNT_W'(fblc_pkg::FREE_DEPTH);
    localparam logic [fblc_pkg::CNT_W-1:0] ONE_CNT  = fblc_pkg::CNT_W'(1);

    fblc_pkg::state_t                   state_reg, state_next;
    logic [fblc_pkg::CNT_W-1:0]         used_reg, used_next;
    logic [fblc_pkg::WORD_W-1:0]        data_end_reg, data_end_next;
    logic                               done_reg, done_next;
    logic                               status_reg, status_next;

    logic [fblc_pkg::WORD_W-1:0]        off_reg, off_next;
    logic [fblc_pkg::WORD_W-1:0]        size_reg, size_next;
    logic [fblc_pkg::CNT_W-1:0]         scan_reg, scan_next;
    logic [fblc_pkg::CNT_W-1:0]         mv_reg, mv_next;
    logic                               up_reg, up_next;
    logic                               has_next_reg, has_next_next;
    logic                               prev_touch_reg, prev_touch_next;
    fblc_pkg::entry_t                   prev_reg, prev_next;
    fblc_pkg::entry_t                   nxt_reg, nxt_next;
    fblc_pkg::entry_t                   cur_reg, cur_next;

    logic [fblc_pkg::CNT_W-1:0]         scan_m1;
    logic [fblc_pkg::CNT_W-1:0]         mv_m1;
    logic [fblc_pkg::CNT_W-1:0]         mv_p1;
    logic [fblc_pkg::WORD_W:0]          prev_sum;
    logic [fblc_pkg::WORD_W:0]          cur_sum;

    assign scan_m1  = scan_reg - ONE_CNT;
    assign mv_m1    = mv_reg - ONE_CNT;
    assign mv_p1    = mv_reg + ONE_CNT;
    assign prev_sum = {1'b0, prev_reg.off} + {1'b0, prev_reg.size};
    assign cur_sum  = {1'b0, cur_reg.off} + {1'b0, cur_reg.size};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fblc_pkg::ST_IDLE;
            used_reg     <= '0;
            data_end_reg <= '0;
            done_reg     <= 1'b0;
            status_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            data_end_reg <= data_end_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg        <= off_next;
        size_reg       <= size_next;
        scan_reg       <= scan_next;
        mv_reg         <= mv_next;
        up_reg         <= up_next;
        has_next_reg   <= has_next_next;
        prev_touch_reg <= prev_touch_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        cur_reg        <= cur_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        data_end_next   = data_end_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        off_next        = off_reg;
        size_next       = size_reg;
        scan_next       = scan_reg;
        mv_next         = mv_reg;
        up_next         = up_reg;
        has_next_next   = has_next_reg;
        prev_touch_next = prev_touch_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        cur_next        = cur_reg;
        wr              = '0;
        rd_addr         = scan_reg[fblc_pkg::IDX_W-1:0];

        case (state_reg)
            fblc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    status_next = 1'b0;
                    case (fblc_pkg::op_t'(operation))
                        fblc_pkg::OP_RELEASE:
                        begin
                            off_next      = block_offset;
                            size_next     = block_size;
                            scan_next     = '0;
                            has_next_next = 1'b0;
                            state_next    = fblc_pkg::ST_SRCH_RD;
                        end
                        fblc_pkg::OP_APPEND:
                        begin
                            if (used_reg == FULL_CNT)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                wr.we        = 1'b1;
                                wr.addr      = used_reg[fblc_pkg::IDX_W-1:0];
                                wr.data.off  = block_offset;
                                wr.data.size = block_size;
                                used_next    = used_reg + ONE_CNT;
                            end
                            done_next = 1'b1;
                        end
                        fblc_pkg::OP_SET_END:
                        begin
                            data_end_next = block_offset;
                            done_next     = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            fblc_pkg::ST_SRCH_RD:
            begin
                if (scan_reg == used_reg)
                begin
                    state_next = fblc_pkg::ST_DEC1;
                end
                else
                begin
                    rd_addr    = scan_reg[fblc_pkg::IDX_W-1:0];
                    state_next = fblc_pkg::ST_SRCH_CHK;
                end
            end

            fblc_pkg::ST_SRCH_CHK:
            begin
                if (off_reg < rd_data.off)
                begin
                    nxt_next      = rd_data;
                    has_next_next = 1'b1;
                    state_next    = fblc_pkg::ST_DEC1;
                end
                else
                begin
                    prev_next  = rd_data;
                    scan_next  = scan_reg + ONE_CNT;
                    state_next = fblc_pkg::ST_SRCH_RD;
                end
            end

            fblc_pkg::ST_DEC1:
            begin
                if ((scan_reg != '0) && (prev_sum == {1'b0, off_reg}))
                begin
                    prev_touch_next = 1'b1;
                    cur_next.off    = prev_reg.off;
                    cur_next.size   = fblc_pkg::sat_add(prev_reg.size, size_reg);
                end
                else
                begin
                    prev_touch_next = 1'b0;
                    cur_next.off    = off_reg;
                    cur_next.size   = size_reg;
                end
                state_next = fblc_pkg::ST_DEC2;
            end

            fblc_pkg::ST_DEC2:
            begin
                if (has_next_reg && (cur_sum == {1'b0, nxt_reg.off}))
                begin
                    // merge into following entry
                    wr.we        = 1'b1;
                    wr.data.off  = cur_reg.off;
                    wr.data.size = fblc_pkg::sat_add(nxt_reg.size, cur_reg.size);
                    if (prev_touch_reg)
                    begin
                        wr.addr    = scan_m1[fblc_pkg::IDX_W-1:0];
                        mv_next    = scan_reg;
                        up_next    = 1'b0;
                        state_next = fblc_pkg::ST_MOVE_RD;
                    end
                    else
                    begin
                        wr.addr    = scan_reg[fblc_pkg::IDX_W-1:0];
                        done_next  = 1'b1;
                        state_next = fblc_pkg::ST_IDLE;
                    end
                end
                else if (!has_next_reg && (cur_sum >= {1'b0, data_end_reg}))
                begin
                    // tail block gives space back to data end
                    data_end_next = cur_reg.off;
                    if (prev_touch_reg)
                    begin
                        used_next = used_reg - ONE_CNT;
                    end
                    done_next  = 1'b1;
                    state_next = fblc_pkg::ST_IDLE;
                end
                else if (prev_touch_reg)
                begin
                    wr.we      = 1'b1;
                    wr.addr    = scan_m1[fblc_pkg::IDX_W-1:0];
                    wr.data    = cur_reg;
                    done_next  = 1'b1;
                    state_next = fblc_pkg::ST_IDLE;
                end
                else if (used_reg == FULL_CNT)
                begin
                    status_next = 1'b1;
                    done_next   = 1'b1;
                    state_next  = fblc_pkg::ST_IDLE;
                end
                else
                begin
                    mv_next    = used_reg;
                    up_next    = 1'b1;
                    state_next = fblc_pkg::ST_MOVE_RD;
                end
            end

            fblc_pkg::ST_MOVE_RD:
            begin
                if (up_reg)
                begin
                    if (mv_reg == scan_reg)
                    begin
                        state_next = fblc_pkg::ST_PUT;
                    end
                    else
                    begin
                        rd_addr    = mv_m1[fblc_pkg::IDX_W-1:0];
                        state_next = fblc_pkg::ST_MOVE_WR;
                    end
                end
                else
                begin
                    if (mv_p1 >= used_reg)
                    begin
                        used_next  = used_reg - ONE_CNT;
                        done_next  = 1'b1;
                        state_next = fblc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        rd_addr    = mv_p1[fblc_pkg::IDX_W-1:0];
                        state_next = fblc_pkg::ST_MOVE_WR;
                    end
                end
            end

            fblc_pkg::ST_MOVE_WR:
            begin
                wr.we      = 1'b1;
                wr.addr    = mv_reg[fblc_pkg::IDX_W-1:0];
                wr.data    = rd_data;
                mv_next    = up_reg ? mv_m1 : mv_p1;
                state_next = fblc_pkg::ST_MOVE_RD;
            end

            fblc_pkg::ST_PUT:
            begin
                wr.we      = 1'b1;
                wr.addr    = scan_reg[fblc_pkg::IDX_W-1:0];
                wr.data    = cur_reg;
                used_next  = used_reg + ONE_CNT;
                done_next  = 1'b1;
                state_next = fblc_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = fblc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != fblc_pkg::ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign entry_count  = 7'(used_reg);
    assign data_end_now = data_end_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= FULL_CNT)
        else $error("free list count beyond depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg) |-> (used_reg == FULL_CNT))
        else $error("full status with room left");

    a_count_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> done_reg)
        else $error("entry count changed without a result");

    a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> (fblc_pkg::CNT_W'(wr.addr) <= used_reg))
        else $error("write beyond end of list");

    a_shift_up: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == fblc_pkg::ST_MOVE_WR) && up_reg) |-> (mv_reg > scan_reg))
        else $error("insert shift past slot");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fblc_pkg::ST_SRCH_CHK) |-> (scan_reg < used_reg))
        else $error("search read beyond list");

endmodule

### rtl/core/free_block_list_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_block_list_coalescer - sorted free list with coalescing
// Offset-sorted list of free blocks in RAM, plus a data end offset.
// ----------------------------------------------------------------------------
// Usage:
//   Drive operation, block_offset and block_size and raise start; the transfer
//   is taken at a clock edge with start high and busy low. busy stays high
//   until the result is presented.
//   Each item gives one result: status, entry_count and data_end_now are valid
//   for the single cycle in which done is high. The receiver cannot stall;
//   the result must be captured in that cycle.
//   Append, set data end and unused codes: done in the cycle after the
//   transfer.
//   Release: the list RAM (one read, one write port, registered read) sets
//   the pace. The slot search reads and then checks one entry at a time,
//   the merge decision passes ST_DEC1 and ST_DEC2, and each entry shifted
//   for an insert or removal is read and then written. A final ST_MOVE_RD
//   check closes the shift; an insert then writes in ST_PUT. done rises in
//   the cycle after the last busy state. One item is in work at a time.
//   Reset clears the entry count and data end; no RAM clearing pass.
// ----------------------------------------------------------------------------
module free_block_list_coalescer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  operation,
    input  logic [fblc_pkg::WORD_W-1:0] block_offset,
    input  logic [fblc_pkg::WORD_W-1:0] block_size,
    output logic                        done,
    output logic                        status,
    output logic [6:0]                  entry_count,
    output logic [fblc_pkg::WORD_W-1:0] data_end_now
);

    fblc_pkg::ram_wr_t          wr;
    logic [fblc_pkg::IDX_W-1:0] rd_addr;
    fblc_pkg::entry_t           rd_data;

    fblc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .operation    (operation),
        .block_offset (block_offset),
        .block_size   (block_size),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .entry_count  (entry_count),
        .data_end_now (data_end_now),
        .wr           (wr),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    fblc_ram #(
        .WIDTH ($bits(fblc_pkg::entry_t)),
        .DEPTH (fblc_pkg::FREE_DEPTH)
    ) u_list_ram (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.addr),
        .wdata (wr.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

endmodule

### tb/tb_free_block_list_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_block_list_coalescer - self-checking bench for the free list coalescer
// Drives release, append, set-end and unused items through the start/busy
// handshake and predicts every done strobe from a local copy of the sorted
// free list. Directed merge and extreme cases run first, then random carve,
// drain, fill and noise sequences with random idle gaps on the sender.
// ----------------------------------------------------------------------------
module tb_free_block_list_coalescer;

    import fblc_pkg::*;

    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam int unsigned TOTAL_ITEMS    = 1050;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 300;

    typedef struct packed {
        logic              status;
        logic [6:0]        count;
        logic [WORD_W-1:0] end_off;
    } list_report_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        operation;
    logic [WORD_W-1:0] block_offset;
    logic [WORD_W-1:0] block_size;
    logic              done;
    logic              status;
    logic [6:0]        entry_count;
    logic [WORD_W-1:0] data_end_now;

    // predicted free list
    logic [WORD_W-1:0] fl_off  [FREE_DEPTH];
    logic [WORD_W-1:0] fl_size [FREE_DEPTH];
    int unsigned       fl_used = 0;
    logic [WORD_W-1:0] fl_end  = '0;

    list_report_t      pending_reports [$];
    list_report_t      due;
    int unsigned       mismatches   = 0;
    int unsigned       items_sent   = 0;
    int unsigned       stall_cycles = 0;

    free_block_list_coalescer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .block_offset (block_offset),
        .block_size   (block_size),
        .done         (done),
        .status       (status),
        .entry_count  (entry_count),
        .data_end_now (data_end_now)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] capped_sum(input logic [WORD_W-1:0] a,
                                                     input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, {WORD_W{1'b1}}})
            return {WORD_W{1'b1}};
        return s[WORD_W-1:0];
    endfunction

    function automatic void drop_entry(input int unsigned k);
        int unsigned j;
        if (k >= fl_used)
            return;
        for (j = k; j + 1 < fl_used; j++)
        begin
            fl_off[j]  = fl_off[j + 1];
            fl_size[j] = fl_size[j + 1];
        end
        fl_used--;
    endfunction

    function automatic logic place_entry(input int unsigned k, input logic [WORD_W-1:0] off,
                                         input logic [WORD_W-1:0] size);
        int unsigned j;
        if (fl_used >= FREE_DEPTH || k > fl_used)
            return 1'b1;
        for (j = fl_used; j > k; j--)
        begin
            fl_off[j]  = fl_off[j - 1];
            fl_size[j] = fl_size[j - 1];
        end
        fl_off[k]  = off;
        fl_size[k] = size;
        fl_used++;
        return 1'b0;
    endfunction

    function automatic logic free_block(input logic [WORD_W-1:0] off,
                                        input logic [WORD_W-1:0] size);
        int unsigned i;
        logic        merged;
        i      = 0;
        merged = 1'b0;
        while (i < fl_used && !(off < fl_off[i]))
            i++;
        if (i > 0 && ({1'b0, fl_off[i - 1]} + fl_size[i - 1] == {1'b0, off}))
        begin
            fl_size[i - 1] = capped_sum(fl_size[i - 1], size);
            off            = fl_off[i - 1];
            size           = fl_size[i - 1];
            merged         = 1'b1;
        end
        if (i < fl_used)
        begin
            if ({1'b0, off} + size == {1'b0, fl_off[i]})
            begin
                fl_size[i] = capped_sum(fl_size[i], size);
                fl_off[i]  = off;
                if (merged)
                    drop_entry(i - 1);
                merged = 1'b1;
            end
        end
        else if ({1'b0, off} + size >= {1'b0, fl_end})
        begin
            fl_end = off;
            if (merged)
                drop_entry(i - 1);
            merged = 1'b1;
        end
        if (!merged)
            return place_entry(i, off, size);
        return 1'b0;
    endfunction

    function automatic list_report_t update_free_list(input logic [1:0] op,
                                                      input logic [WORD_W-1:0] off,
                                                      input logic [WORD_W-1:0] size);
        list_report_t r;
        r.status = 1'b0;
        case (op)
            OP_RELEASE: r.status = free_block(off, size);
            OP_APPEND:  r.status = place_entry(fl_used, off, size);
            OP_SET_END: fl_end = off;
            default:    ;
        endcase
        r.count   = 7'(fl_used);
        r.end_off = fl_end;
        return r;
    endfunction

    // true when no entry has an offset above x
    function automatic logic tail_is_clear(input logic [WORD_W-1:0] x);
        int unsigned j;
        for (j = 0; j < fl_used; j++)
            if (fl_off[j] > x)
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic idle_gap();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 280) : $urandom_range(1, 4);
        repeat (n)
        begin
            @(negedge clk);
            start        <= 1'b0;
            operation    <= 2'($urandom);
            block_offset <= $urandom;
            block_size   <= $urandom;
        end
    endtask

    task automatic send_item(input logic [1:0] op, input logic [WORD_W-1:0] off,
                             input logic [WORD_W-1:0] size);
        if (!(items_sent >= 400 && items_sent < 600) && $urandom_range(0, 99) < 38)
            idle_gap();
        @(negedge clk);
        start        <= 1'b1;
        operation    <= op;
        block_offset <= off;
        block_size   <= size;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_reports.push_back(update_free_list(op, off, size));
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
                flag_mismatch("unexpected result, data end", '0, data_end_now);
            else
            begin
                due = pending_reports.pop_front();
                if (status !== due.status)
                    flag_mismatch("status", WORD_W'(due.status), WORD_W'(status));
                if (entry_count !== due.count)
                    flag_mismatch("entry_count", WORD_W'(due.count), WORD_W'(entry_count));
                if (data_end_now !== due.end_off)
                    flag_mismatch("data_end_now", due.end_off, data_end_now);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** free_block_list_coalescer: FAILED **");
            $finish;
        end
    end

    task automatic test_merge_paths();
        send_item(OP_SET_END, 32'd1000, 32'hFFFF_FFFF);
        send_item(OP_APPEND,  32'd100,  32'd50);
        send_item(OP_APPEND,  32'd300,  32'd100);
        send_item(OP_RELEASE, 32'd150,  32'd50);
        send_item(OP_RELEASE, 32'd200,  32'd100);
        send_item(OP_RELEASE, 32'd600,  32'd400);
        send_item(OP_RELEASE, 32'd400,  32'd200);
        send_item(OP_RELEASE, 32'd50,   32'd10);
        send_item(OP_RELEASE, 32'd40,   32'd10);
        send_item(OP_RELEASE, 32'd0,    32'd0);
        send_item(OP_RELEASE, 32'd0,    32'd0);
        send_item(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_field_extremes();
        send_item(OP_SET_END, 32'hFFFF_FFFF, 32'd0);
        send_item(OP_APPEND,  32'h8000_0000, 32'h7FFF_FFFF);
        // merged size saturates, then data end drops
        send_item(OP_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_APPEND,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_APPEND,  32'd20,        32'd5);
        send_item(OP_RELEASE, 32'd25,        32'd15);
        send_item(OP_RELEASE, 32'hFFFF_FFFE, 32'd1);
        send_item(OP_SET_END, 32'd0,         32'hFFFF_FFFF);
        send_item(OP_RELEASE, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(OP_RELEASE, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic run_carve_phase();
        logic [WORD_W-1:0] cut_off [12];
        logic [WORD_W-1:0] cut_len [12];
        int unsigned       order   [12];
        int unsigned       pieces, j, pick, tmp;
        logic [WORD_W:0]   total, tail;
        logic [WORD_W-1:0] base, running;
        pieces = $urandom_range(2, 12);
        total  = '0;
        for (j = 0; j < pieces; j++)
        begin
            case ($urandom_range(0, 15))
                0, 1:    cut_len[j] = '0;
                2:       cut_len[j] = $urandom_range(1, 32'h00FF_FFFF);
                default: cut_len[j] = $urandom_range(1, 64);
            endcase
            total    = total + cut_len[j];
            order[j] = j;
        end
        tail = (fl_used != 0) ? {1'b0, fl_off[fl_used - 1]} + fl_size[fl_used - 1] : '0;
        case ($urandom_range(0, 7))
            0:       base = 32'hFFFF_FFFF - total[WORD_W-1:0];
            1, 2:
            begin
                if (fl_used != 0 && tail + total <= {1'b0, 32'hFFFF_FFFF})
                    base = tail[WORD_W-1:0];
                else
                    base = $urandom_range(0, 32'hFFFF_FFFF - total[WORD_W-1:0]);
            end
            default: base = $urandom_range(0, 32'hFFFF_FFFF - total[WORD_W-1:0]);
        endcase
        running = base;
        for (j = 0; j < pieces; j++)
        begin
            cut_off[j] = running;
            running    = running + cut_len[j];
        end
        case ($urandom_range(0, 3))
            0:       ;
            1:       send_item(OP_SET_END, (running < 32'hFFFF_FF00) ?
                               running + $urandom_range(1, 16) : running, $urandom);
            default: send_item(OP_SET_END, running, $urandom);
        endcase
        for (j = pieces - 1; j > 0; j--)
        begin
            pick        = $urandom_range(0, j);
            tmp         = order[j];
            order[j]    = order[pick];
            order[pick] = tmp;
        end
        for (j = 0; j < pieces; j++)
            if ($urandom_range(0, 9) != 0)
                send_item(OP_RELEASE, cut_off[order[j]], cut_len[order[j]]);
    endtask

    task automatic run_drain_phase();
        logic [WORD_W:0]   tail;
        logic [WORD_W-1:0] span;
        int unsigned       rounds;
        rounds = $urandom_range(4, 40);
        send_item(OP_SET_END, '0, $urandom);
        while (rounds != 0 && fl_used != 0)
        begin
            tail = {1'b0, fl_off[fl_used - 1]} + fl_size[fl_used - 1];
            if (!tail[WORD_W] && tail_is_clear(tail[WORD_W-1:0]))
            begin
                span = (fl_end > tail[WORD_W-1:0]) ? fl_end - tail[WORD_W-1:0]
                                                   : $urandom_range(0, 64);
                send_item(OP_RELEASE, tail[WORD_W-1:0], span);
            end
            else
                send_item(OP_RELEASE, $urandom, $urandom_range(0, 64));
            rounds--;
        end
    endtask

    task automatic run_fill_phase();
        logic [WORD_W-1:0] cursor, len;
        int unsigned       extra;
        cursor = $urandom_range(0, 32'h8000_0000);
        extra  = $urandom_range(1, 4);
        while (fl_used < FREE_DEPTH || extra != 0)
        begin
            if (fl_used >= FREE_DEPTH)
                extra--;
            len = $urandom_range(0, 64);
            if ($urandom_range(0, 19) == 0)
                send_item(OP_APPEND, $urandom, len);
            else
                send_item(OP_APPEND, cursor, len);
            cursor = cursor + len + $urandom_range(1, 1000);
        end
        send_item(OP_SET_END, 32'hFFFF_FFFF, $urandom);
        send_item(OP_RELEASE, cursor + 32'd10, $urandom_range(1, 64));
    endtask

    task automatic run_noise_phase();
        repeat ($urandom_range(3, 12))
            send_item(2'($urandom_range(0, 3)), $urandom,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom);
    endtask

    task automatic test_random_traffic();
        int unsigned kind;
        wait_for_results();
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 11) == 0)
                wait_for_results();
            kind = $urandom_range(0, 99);
            if (kind < 55)
                run_carve_phase();
            else if (kind < 75)
                run_drain_phase();
            else if (kind < 83)
                run_fill_phase();
            else
                run_noise_phase();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_RELEASE;
        block_offset = '0;
        block_size   = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        test_merge_paths();
        test_field_extremes();
        test_random_traffic();
        @(negedge clk);
        start <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** free_block_list_coalescer: PASSED **");
        else
            $display("** free_block_list_coalescer: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/core/fblc_pkg.sv
rtl/core/fblc_ram.sv
rtl/core/fblc_ctrl.sv
rtl/core/free_block_list_coalescer.sv
tb/tb_free_block_list_coalescer.sv
